// File: sv/i2c_mrw_pkg.sv
`default_nettype none

package i2c_mrw_pkg;

  // field widths
  localparam int unsigned TicksW   = 16;
  localparam int unsigned SegW     = 5;
  localparam int unsigned PhaseW   = 3;
  localparam int unsigned FrameW   = 23;
  localparam int unsigned AckCntW  = 2;
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 8;
  localparam int unsigned PaddrW   = 3;

  // segment numbers of the write frame
  localparam logic [SegW-1:0] SegStart   = 5'd0;
  localparam logic [SegW-1:0] SegAddrLo  = 5'd1;
  localparam logic [SegW-1:0] SegAddrHi  = 5'd7;
  localparam logic [SegW-1:0] SegAckDev  = 5'd9;
  localparam logic [SegW-1:0] SegRegLo   = 5'd10;
  localparam logic [SegW-1:0] SegRegHi   = 5'd17;
  localparam logic [SegW-1:0] SegAckReg  = 5'd18;
  localparam logic [SegW-1:0] SegDataLo  = 5'd19;
  localparam logic [SegW-1:0] SegDataHi  = 5'd26;
  localparam logic [SegW-1:0] SegAckData = 5'd27;
  localparam logic [SegW-1:0] SegStop    = 5'd28;

  // phases per segment
  localparam logic [PhaseW-1:0] PhasesAck = 3'd5;
  localparam logic [PhaseW-1:0] PhasesStd = 3'd3;

  // phase numbers
  localparam logic [PhaseW-1:0] Ph0 = 3'd0;
  localparam logic [PhaseW-1:0] Ph1 = 3'd1;
  localparam logic [PhaseW-1:0] Ph2 = 3'd2;
  localparam logic [PhaseW-1:0] Ph3 = 3'd3;

  // register index of the config port
  localparam logic RegPhaseTicks = 1'b0;

  localparam logic [TicksW-1:0] PhaseTicksRst = 16'd1;

  // pin latch: {drive, sda, scl}
  typedef struct packed {
    logic drv;
    logic sda;
    logic scl;
  } pins_t;

  // result word, scl in bit 0
  typedef struct packed {
    logic                 pad;
    logic [AckCntW-1:0]   ack_count;
    logic                 done_res;
    logic                 busy_res;
    logic                 sda_drive;
    logic                 sda_level;
    logic                 scl_level;
  } out_word_t;

  function automatic logic seg_is_ack(input logic [SegW-1:0] s);
    return (s == SegAckDev) || (s == SegAckReg) || (s == SegAckData);
  endfunction

  function automatic logic seg_is_data(input logic [SegW-1:0] s);
    return ((s >= SegAddrLo) && (s <= SegAddrHi)) ||
           ((s >= SegRegLo)  && (s <= SegRegHi))  ||
           ((s >= SegDataLo) && (s <= SegDataHi));
  endfunction

endpackage

`default_nettype wire

// File: sv/i2c_master_register_write.sv
// A result word is registered and presented in the cycle after its tick word is accepted.
// Throughput: one tick word per cycle unless a held result word stalls; the sequencer advances once per word.
// An output register decouples the sides; s_axis_tready drops only while a
//   result word is held and m_axis_tready is low.
// Reset (rst_ni low, asynchronous): idle, SCL and SDA high and driven,
//   ack count 0, phase_ticks 1, no result word pending.
`default_nettype none

module i2c_master_register_write (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  // tick words
  input  wire                                s_axis_tvalid,
  output logic                               s_axis_tready,
  // [6:0] device_address, [14:7] register_address, [22:15] write_data,
  // [23] sda_sample
  input  wire  [i2c_mrw_pkg::InDataW-1:0]    s_axis_tdata,
  // [0] action
  input  wire                                s_axis_tuser,
  // result words
  output logic                               m_axis_tvalid,
  input  wire                                m_axis_tready,
  // [0] scl_level, [1] sda_level, [2] sda_drive, [3] busy_res,
  // [4] done_res, [6:5] ack_count, [7] zero
  output logic [i2c_mrw_pkg::OutDataW-1:0]   m_axis_tdata,
  // config port
  input  wire                                psel,
  input  wire                                penable,
  input  wire                                pwrite,
  input  wire  [i2c_mrw_pkg::PaddrW-1:0]     paddr,
  input  wire  [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  import i2c_mrw_pkg::*;

  logic                 active_q, active_d;
  logic [SegW-1:0]      seg_q, seg_d;
  logic [PhaseW-1:0]    ph_q, ph_d;
  logic [TicksW-1:0]    tick_q, tick_d;
  logic [FrameW-1:0]    frame_q, frame_d;
  logic [AckCntW-1:0]   acks_q, acks_d;
  pins_t                pins_q, pins_d;
  logic [TicksW-1:0]    phase_ticks_q;
  logic                 out_valid_q;
  out_word_t            out_q, out_d;

  logic                 in_fire;
  logic                 start;
  logic                 run;
  logic [SegW-1:0]      seg;
  logic [PhaseW-1:0]    ph;
  logic [TicksW-1:0]    tick;
  logic [FrameW-1:0]    frame;
  logic [AckCntW-1:0]   acks;
  logic [TicksW-1:0]    limit;
  logic [TicksW:0]      tick_inc;
  logic [PhaseW-1:0]    ph_inc;
  logic                 phase_end;
  logic                 seg_end;
  logic                 done;
  logic                 tx_bit;
  logic                 sda_in;
  logic                 cfg_wr;

  assign sda_in  = s_axis_tdata[23];
  assign in_fire = s_axis_tvalid && s_axis_tready;

  // config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == RegPhaseTicks);
  assign prdata = (paddr[2] == RegPhaseTicks) ? {16'd0, phase_ticks_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_ticks_q <= PhaseTicksRst;
    end else if (cfg_wr) begin
      phase_ticks_q <= pwdata[TicksW-1:0];
    end
  end

  // a request while idle restarts the frame state
  assign start = !active_q && s_axis_tuser;
  assign run   = active_q || start;
  assign seg   = start ? SegStart : seg_q;
  assign ph    = start ? Ph0 : ph_q;
  assign tick  = start ? '0 : tick_q;
  assign acks  = start ? '0 : acks_q;
  assign frame = start ? {s_axis_tdata[6:0], s_axis_tdata[14:7], s_axis_tdata[22:15]}
                       : frame_q;
  // frame bits are device, register, data from MSB down
  assign tx_bit = seg_is_data(seg) ? frame[FrameW-1] : 1'b0;

  // phase timing
  assign limit     = (phase_ticks_q == '0) ? PhaseTicksRst : phase_ticks_q;
  assign tick_inc  = {1'b0, tick} + {{TicksW{1'b0}}, 1'b1};
  assign ph_inc    = ph + 3'd1;
  assign phase_end = run && (tick_inc >= {1'b0, limit});
  assign seg_end   = phase_end &&
                     (ph_inc >= (seg_is_ack(seg) ? PhasesAck : PhasesStd));
  assign done      = seg_end && (seg >= SegStop);

  // pin actions on the first tick of a phase
  always_comb begin
    pins_d = pins_q;
    acks_d = acks;
    if (run && (tick == '0)) begin
      priority if (seg == SegStart) begin
        priority if (ph == Ph0) pins_d.scl = 1'b1;
        else if (ph == Ph1)     pins_d.sda = 1'b0;
        else                    pins_d.scl = 1'b0;
      end else if (seg == SegStop) begin
        priority if (ph == Ph0) pins_d.sda = 1'b0;
        else if (ph == Ph1)     pins_d.scl = 1'b1;
        else                    pins_d.sda = 1'b1;
      end else if (seg_is_ack(seg)) begin
        priority if (ph == Ph0) pins_d.drv = 1'b0;
        else if (ph == Ph1)     pins_d.scl = 1'b1;
        else if (ph == Ph2) begin
          if (!sda_in && (acks != 2'd3)) acks_d = acks + 2'd1;
        end else if (ph == Ph3) pins_d.scl = 1'b0;
        else                    pins_d.drv = 1'b1;
      end else begin
        priority if (ph == Ph0) pins_d.sda = tx_bit;
        else if (ph == Ph1)     pins_d.scl = 1'b1;
        else                    pins_d.scl = 1'b0;
      end
    end
  end

  // sequencer next state
  always_comb begin
    active_d = active_q;
    seg_d    = seg_q;
    ph_d     = ph_q;
    tick_d   = tick_q;
    frame_d  = frame_q;
    if (run) begin
      active_d = !done;
      seg_d    = seg;
      ph_d     = ph;
      frame_d  = frame;
      tick_d   = phase_end ? '0 : tick_inc[TicksW-1:0];
      if (phase_end) begin
        ph_d = seg_end ? Ph0 : ph_inc;
      end
      if (seg_end) begin
        if (seg_is_data(seg)) frame_d = {frame[FrameW-2:0], 1'b0};
        seg_d = done ? SegStart : seg + 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      seg_q    <= SegStart;
      ph_q     <= Ph0;
      tick_q   <= '0;
      frame_q  <= '0;
      acks_q   <= '0;
      pins_q   <= '{drv: 1'b1, sda: 1'b1, scl: 1'b1};
    end else if (in_fire) begin
      active_q <= active_d;
      seg_q    <= seg_d;
      ph_q     <= ph_d;
      tick_q   <= tick_d;
      frame_q  <= frame_d;
      acks_q   <= acks_d;
      pins_q   <= pins_d;
    end
  end

  // result word
  always_comb begin
    out_d.pad       = 1'b0;
    out_d.ack_count = acks_d;
    out_d.done_res  = done;
    out_d.busy_res  = run;
    out_d.sda_drive = pins_d.drv;
    out_d.sda_level = pins_d.sda;
    out_d.scl_level = pins_d.scl;
  end

  // output register
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_q <= out_d;
    end
  end

endmodule

`default_nettype wire

// File: sv/i2c_mrw_chk.sv
`default_nettype none

module i2c_mrw_chk (
  input wire                                clk_i,
  input wire                                rst_ni,
  input wire                                s_axis_tvalid,
  input wire                                s_axis_tready,
  input wire                                m_axis_tvalid,
  input wire                                m_axis_tready,
  input wire [i2c_mrw_pkg::OutDataW-1:0]    m_axis_tdata
);
  import i2c_mrw_pkg::*;

  out_word_t ow;
  assign ow = m_axis_tdata;

  // done only ever shows on a busy word
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && ow.done_res |-> ow.busy_res)
    else $error("done without busy");

  // SDA is released only inside a transaction
  a_release_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !ow.sda_drive |-> ow.busy_res)
    else $error("sda released while idle");

  // a new result word appears only after a tick word was taken
  a_out_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready))
    else $error("result word without tick word");

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result word changed");

endmodule

bind i2c_master_register_write i2c_mrw_chk u_i2c_mrw_chk (.*);

`default_nettype wire
